FILE: hdl/scroll_to_line_snapper_assert.svh
// ----------------------------------------------------------------------------
// scroll_to_line_snapper assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SCROLL_TO_LINE_SNAPPER_ASSERT_SVH
`define SCROLL_TO_LINE_SNAPPER_ASSERT_SVH

`ifndef SYNTH
// plain property, checked on every edge out of reset
`define STLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication with an overlapping antecedent
`define STLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// implication with a non-overlapping antecedent, checked in the next cycle
`define STLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STLS_ASSERT(lbl, prop, msg)
`define STLS_ASSERT_IMP(lbl, ante, cons, msg)
`define STLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/stls_pkg.sv
// ----------------------------------------------------------------------------
// stls_pkg
// Event codes, register indexes, reset values and helpers of the line snapper.
// ----------------------------------------------------------------------------
`default_nettype none

package stls_pkg;

  // event kinds carried in tuser
  localparam logic [2:0] FUNC_MOTION_START  = 3'd0;
  localparam logic [2:0] FUNC_INERTIA_START = 3'd1;
  localparam logic [2:0] FUNC_MOTION_STOP   = 3'd2;
  localparam logic [2:0] FUNC_INERTIA_STOP  = 3'd3;
  localparam logic [2:0] FUNC_PIXEL         = 3'd4;
  localparam logic [2:0] FUNC_LINE          = 3'd5;
  localparam logic [2:0] FUNC_HALT_UP       = 3'd6;
  localparam logic [2:0] FUNC_HALT_DOWN     = 3'd7;

  // configuration register indexes
  localparam logic [1:0] REG_PIXEL_SCALE = 2'd0;
  localparam logic [1:0] REG_LINE_SCALE  = 2'd1;
  localparam logic [1:0] REG_VIEW_BASED  = 2'd2;
  localparam logic [1:0] REG_MIN_LINES   = 2'd3;

  localparam logic [15:0] PIXEL_SCALE_RST = 16'd256;
  localparam logic [23:0] LINE_SCALE_RST  = 24'd65536;
  localparam logic [15:0] MIN_LINES_RST   = 16'd1;

  // inertia start this soon after a stop keeps the halt flags
  localparam logic [31:0] CARRY_MS = 32'd50;

  localparam int unsigned DIV_BITS = 24;

  // sign and magnitude to a saturated 16 bit two's complement value
  function automatic logic [15:0] sat16(input logic neg, input logic [39:0] mag);
    logic [15:0] res;
    if (neg) begin
      if (mag > 40'd32768) res = 16'h8000;
      else                 res = 16'(16'd0 - mag[15:0]);
    end else begin
      if (mag > 40'd32767) res = 16'h7fff;
      else                 res = mag[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/scroll_to_line_snapper.sv
// ----------------------------------------------------------------------------
// scroll_to_line_snapper
// Converts scroll events into a signed, saturated count of text lines.
// ----------------------------------------------------------------------------
// One event is taken at a time; the input is not ready while an event is in
// work. Control and halt events, and pixel scrolls dropped in a halted
// direction, go straight to the done state. A line scroll makes three passes
// through the shared 24x17 multiplier (gain times view, then two partial
// products), followed by rounding and the minimum magnitude. A pixel scroll
// ends in the bit-serial divide of the scaled amount by the line height, one
// quotient bit per cycle for 24 bits. The result sits in an output register,
// so the next event is taken while it waits for the sink. There is one
// result per event; control events give zero.
`default_nettype none

module scroll_to_line_snapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // scroll_amount[15:0], time_ms[47:16], line_height[55:48], view_lines[71:56]
  input  wire logic [71:0] s_axis_tdata_i,
  // func[2:0]
  input  wire logic [2:0]  s_axis_tuser_i,
  // master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // lines[15:0]
  output logic [15:0]      m_axis_tdata_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [23:0] cfg_wdata_i
);

`include "scroll_to_line_snapper_assert.svh"

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PMUL  = 4'd1;
  localparam logic [3:0] ST_PRND  = 4'd2;
  localparam logic [3:0] ST_PDIV  = 4'd3;
  localparam logic [3:0] ST_PFIN  = 4'd4;
  localparam logic [3:0] ST_LGAIN = 4'd5;
  localparam logic [3:0] ST_LLO   = 4'd6;
  localparam logic [3:0] ST_LHI   = 4'd7;
  localparam logic [3:0] ST_LRND  = 4'd8;
  localparam logic [3:0] ST_LFIN  = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  localparam logic [4:0] DIV_LAST = 5'(stls_pkg::DIV_BITS - 1);

  // control state
  logic [3:0]  state_q, state_d;
  logic        in_motion_q, in_motion_d;
  logic        inertial_q, inertial_d;
  logic [8:0]  pend_q, pend_d;
  logic        halt_up_q, halt_up_d;
  logic        halt_down_q, halt_down_d;
  logic [31:0] stop_time_q, stop_time_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        m_valid_q, m_valid_d;

  // configuration
  logic [15:0] pix_scale_q;
  logic [23:0] line_scale_q;
  logic        view_based_q;
  logic [15:0] min_lines_q;

  // datapath
  logic        sign_q, sign_d;
  logic [16:0] mag_q, mag_d;
  logic [7:0]  height_q, height_d;
  logic [15:0] view_q, view_d;
  logic [55:0] acc_q, acc_d;
  logic [39:0] gain_q, gain_d;
  logic [23:0] dvd_q, dvd_d;
  logic [7:0]  rem_q, rem_d;
  logic [15:0] res_q, res_d;
  logic [15:0] m_data_q, m_data_d;

  // shared multiplier
  logic [23:0] mul_a;
  logic [16:0] mul_b;
  logic [40:0] mul_p;

  // input fields
  logic [15:0] in_amount;
  logic [31:0] in_time;
  logic [7:0]  in_height;
  logic        in_accept;

  // working values
  logic        amt_neg, amt_pos, halted, dir_change;
  logic [8:0]  pend_eff;
  logic [16:0] sum, sum_abs, amt_abs;
  logic [23:0] pq;
  logic        p_up;
  logic [39:0] lq;
  logic        l_up;
  logic [8:0]  div_t;
  logic        div_ge;
  logic [39:0] line_mag;

  assign in_amount = s_axis_tdata_i[15:0];
  assign in_time   = s_axis_tdata_i[47:16];
  assign in_height = s_axis_tdata_i[55:48];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    mul_a = '0;
    mul_b = mag_q;
    case (state_q)
      ST_PMUL:  mul_a = {8'd0, pix_scale_q};
      ST_LGAIN: begin
        mul_a = line_scale_q;
        mul_b = {1'b0, view_q};
      end
      ST_LLO:   mul_a = {4'd0, gain_q[19:0]};
      ST_LHI:   mul_a = {4'd0, gain_q[39:20]};
      default:  mul_a = '0;
    endcase
  end

  assign mul_p = 41'(mul_a) * 41'(mul_b);

  // pixel sum with the carried remainder
  assign amt_neg    = in_amount[15];
  assign amt_pos    = !in_amount[15] && (in_amount != 16'd0);
  assign halted     = (halt_up_q && amt_neg) || (halt_down_q && amt_pos);
  assign dir_change = (pend_q != 9'd0) && (in_amount != 16'd0) && (pend_q[8] != amt_neg);
  assign pend_eff   = (in_motion_q && !dir_change) ? pend_q : 9'd0;
  assign sum        = {in_amount[15], in_amount} + {{8{pend_eff[8]}}, pend_eff};
  assign sum_abs    = sum[16] ? 17'(17'd0 - sum) : sum;
  assign amt_abs    = amt_neg ? 17'(17'd0 - {1'b1, in_amount}) : {1'b0, in_amount};

  // round half to even after the fixed point shift
  assign pq   = acc_q[31:8];
  assign p_up = acc_q[7] && ((acc_q[6:0] != 7'd0) || pq[0]);
  assign lq   = acc_q[55:16];
  assign l_up = acc_q[15] && ((acc_q[14:0] != 15'd0) || lq[0]);

  // restoring divide step
  assign div_t  = {rem_q, dvd_q[stls_pkg::DIV_BITS-1]};
  assign div_ge = (div_t >= {1'b0, height_q});

  assign line_mag = (acc_q[39:0] < {24'd0, min_lines_q}) ? {24'd0, min_lines_q} : acc_q[39:0];

  always_comb begin
    state_d     = state_q;
    in_motion_d = in_motion_q;
    inertial_d  = inertial_q;
    pend_d      = pend_q;
    halt_up_d   = halt_up_q;
    halt_down_d = halt_down_q;
    stop_time_d = stop_time_q;
    cnt_d       = cnt_q;
    sign_d      = sign_q;
    mag_d       = mag_q;
    height_d    = height_q;
    view_d      = view_q;
    acc_d       = acc_q;
    gain_d      = gain_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    res_d       = res_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          height_d = (in_height == 8'd0) ? 8'd1 : in_height;
          view_d   = s_axis_tdata_i[71:56];
          res_d    = '0;
          state_d  = ST_DONE;
          case (s_axis_tuser_i)
            stls_pkg::FUNC_MOTION_START: begin
              in_motion_d = 1'b1;
              inertial_d  = 1'b0;
              pend_d      = '0;
              halt_up_d   = 1'b0;
              halt_down_d = 1'b0;
            end
            stls_pkg::FUNC_INERTIA_START: begin
              in_motion_d = 1'b1;
              inertial_d  = 1'b1;
              pend_d      = '0;
              if (32'(in_time - stop_time_q) >= stls_pkg::CARRY_MS) begin
                halt_up_d   = 1'b0;
                halt_down_d = 1'b0;
              end
            end
            stls_pkg::FUNC_MOTION_STOP, stls_pkg::FUNC_INERTIA_STOP: begin
              in_motion_d = 1'b0;
              inertial_d  = 1'b0;
              pend_d      = '0;
              stop_time_d = in_time;
            end
            stls_pkg::FUNC_PIXEL: begin
              if (in_motion_q && halted) begin
                pend_d = '0;
              end else begin
                sign_d  = sum[16];
                mag_d   = sum_abs;
                state_d = ST_PMUL;
                if (!in_motion_q) begin
                  pend_d      = '0;
                  stop_time_d = '0;
                end
              end
            end
            stls_pkg::FUNC_LINE: begin
              sign_d  = amt_neg;
              mag_d   = amt_abs;
              state_d = ST_LGAIN;
            end
            stls_pkg::FUNC_HALT_UP: halt_up_d = 1'b1;
            default:                halt_down_d = 1'b1;
          endcase
        end
      end
      ST_PMUL: begin
        acc_d   = 56'(mul_p);
        state_d = ST_PRND;
      end
      ST_PRND: begin
        dvd_d   = pq + 24'(p_up);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_PDIV;
      end
      ST_PDIV: begin
        rem_d = div_ge ? 8'(div_t - {1'b0, height_q}) : div_t[7:0];
        dvd_d = {dvd_q[stls_pkg::DIV_BITS-2:0], div_ge};
        cnt_d = 5'(cnt_q + 5'd1);
        if (cnt_q == DIV_LAST) begin
          state_d = ST_PFIN;
        end
      end
      ST_PFIN: begin
        res_d = stls_pkg::sat16(sign_q, {16'd0, dvd_q});
        if (in_motion_q) begin
          pend_d = sign_q ? 9'(9'd0 - {1'b0, rem_q}) : {1'b0, rem_q};
        end
        state_d = ST_DONE;
      end
      ST_LGAIN: begin
        gain_d  = view_based_q ? mul_p[39:0] : {16'd0, line_scale_q};
        state_d = ST_LLO;
      end
      ST_LLO: begin
        acc_d   = 56'(mul_p);
        state_d = ST_LHI;
      end
      ST_LHI: begin
        acc_d   = 56'(acc_q + {mul_p[35:0], 20'd0});
        state_d = ST_LRND;
      end
      ST_LRND: begin
        acc_d   = {16'd0, 40'(lq + 40'(l_up))};
        state_d = ST_LFIN;
      end
      ST_LFIN: begin
        // a zero amount stays zero, otherwise at least min_lines
        res_d   = (mag_q == 17'd0) ? 16'd0 : stls_pkg::sat16(sign_q, line_mag);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_motion_q  <= 1'b0;
      inertial_q   <= 1'b0;
      pend_q       <= '0;
      halt_up_q    <= 1'b0;
      halt_down_q  <= 1'b0;
      stop_time_q  <= '0;
      cnt_q        <= '0;
      m_valid_q    <= 1'b0;
      pix_scale_q  <= stls_pkg::PIXEL_SCALE_RST;
      line_scale_q <= stls_pkg::LINE_SCALE_RST;
      view_based_q <= 1'b0;
      min_lines_q  <= stls_pkg::MIN_LINES_RST;
    end else begin
      state_q     <= state_d;
      in_motion_q <= in_motion_d;
      inertial_q  <= inertial_d;
      pend_q      <= pend_d;
      halt_up_q   <= halt_up_d;
      halt_down_q <= halt_down_d;
      stop_time_q <= stop_time_d;
      cnt_q       <= cnt_d;
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          stls_pkg::REG_PIXEL_SCALE: pix_scale_q  <= cfg_wdata_i[15:0];
          stls_pkg::REG_LINE_SCALE:  line_scale_q <= cfg_wdata_i;
          stls_pkg::REG_VIEW_BASED:  view_based_q <= cfg_wdata_i[0];
          stls_pkg::REG_MIN_LINES:   min_lines_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q   <= sign_d;
    mag_q    <= mag_d;
    height_q <= height_d;
    view_q   <= view_d;
    acc_q    <= acc_d;
    gain_q   <= gain_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    m_data_q <= m_data_d;
  end

  // the input is not ready in the cycle after a transfer
  `STLS_ASSERT_NEXT(a_busy_after_transfer, in_accept, !s_axis_tready_o, "ready right after transfer")
  // motion start clears both halt flags
  `STLS_ASSERT_NEXT(a_motion_start_unhalts, in_accept && (s_axis_tuser_i == stls_pkg::FUNC_MOTION_START), !halt_up_q && !halt_down_q, "halt flag kept over motion start")
  // divider remainder stays below the line height
  `STLS_ASSERT_IMP(a_rem_below_height, state_q == ST_PDIV, rem_q < height_q, "divider remainder out of range")

endmodule

`default_nettype wire

FILE: tb/scroll_to_line_snapper_chk.sv
// ----------------------------------------------------------------------------
// scroll_to_line_snapper_chk
// Watches the event and result streams and the register port of the line
// snapper, predicts the line count of every accepted event and compares it
// with the result that comes out, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module scroll_to_line_snapper_chk (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  // scroll_amount[15:0], time_ms[47:16], line_height[55:48], view_lines[71:56]
  input  wire logic [71:0] s_axis_tdata_i,
  // func[2:0]
  input  wire logic [2:0]  s_axis_tuser_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  // lines[15:0]
  input  wire logic [15:0] m_axis_tdata_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [23:0] cfg_wdata_i,
  output int               fail_cnt_o,
  output int               due_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import stls_pkg::*;

  // register copies
  logic [15:0] px_gain;
  logic [23:0] row_gain;
  logic        per_view;
  logic [15:0] floor_lines;

  // gesture state
  logic              moving;
  logic              coasting;
  logic              block_up;
  logic              block_down;
  logic signed [8:0] carry_px;
  logic [31:0]       stop_ms;

  logic [15:0] lines_due[$];

  function automatic int sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // nearest integer of num / den, halves go to the even side; den > 0
  function automatic longint round_half_even(input longint num, input longint den);
    longint q;
    longint r;
    q = num / den;
    r = num % den;
    if (r < 0) begin
      r = r + den;
      q = q - 1;
    end
    if (2 * r > den || (2 * r == den && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic logic [15:0] snap_event(input logic [2:0] fn, input logic [15:0] raw_amt,
                                             input logic [31:0] stamp,
                                             input logic [7:0] raw_height,
                                             input logic [15:0] view);
    longint amt;
    longint height;
    longint scaled;
    longint lines;
    longint gain;
    longint floor_mag;
    amt    = longint'($signed(raw_amt));
    height = (raw_height == 8'd0) ? 64'sd1 : longint'(raw_height);
    lines  = 0;
    case (fn)
      FUNC_MOTION_START: begin
        moving     = 1'b1;
        coasting   = 1'b0;
        carry_px   = '0;
        block_up   = 1'b0;
        block_down = 1'b0;
      end
      FUNC_INERTIA_START: begin
        moving   = 1'b1;
        coasting = 1'b1;
        carry_px = '0;
        // a fling right after a stop keeps the halted directions
        if (32'(stamp - stop_ms) >= CARRY_MS) begin
          block_up   = 1'b0;
          block_down = 1'b0;
        end
      end
      FUNC_MOTION_STOP, FUNC_INERTIA_STOP: begin
        moving   = 1'b0;
        coasting = 1'b0;
        carry_px = '0;
        stop_ms  = stamp;
      end
      FUNC_PIXEL: begin
        if (moving && ((block_up && amt < 0) || (block_down && amt > 0))) begin
          carry_px = '0;
        end else if (moving) begin
          if (sign_of(longint'(carry_px)) * sign_of(amt) < 0) carry_px = '0;
          scaled   = round_half_even((amt + longint'(carry_px)) * longint'(px_gain), 256);
          carry_px = 9'(scaled % height);
          lines    = scaled / height;
        end else begin
          scaled   = round_half_even(amt * longint'(px_gain), 256);
          carry_px = '0;
          stop_ms  = '0;
          lines    = scaled / height;
        end
      end
      FUNC_LINE: begin
        gain = longint'(row_gain);
        if (per_view) gain = gain * longint'(view);
        lines     = round_half_even(amt * gain, 65536);
        floor_mag = longint'(floor_lines);
        if (-floor_mag < lines && lines < floor_mag) lines = sign_of(amt) * floor_mag;
      end
      FUNC_HALT_UP: block_up = 1'b1;
      default:      block_down = 1'b1;
    endcase
    return clamp16(lines);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [15:0] want;
    if (!rst_ni) begin
      px_gain     = PIXEL_SCALE_RST;
      row_gain    = LINE_SCALE_RST;
      per_view    = 1'b0;
      floor_lines = MIN_LINES_RST;
      moving      = 1'b0;
      coasting    = 1'b0;
      block_up    = 1'b0;
      block_down  = 1'b0;
      carry_px    = '0;
      stop_ms     = '0;
      lines_due.delete();
      fail_cnt_o  = 0;
      due_cnt_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_PIXEL_SCALE: px_gain = cfg_wdata_i[15:0];
          REG_LINE_SCALE:  row_gain = cfg_wdata_i;
          REG_VIEW_BASED:  per_view = cfg_wdata_i[0];
          REG_MIN_LINES:   floor_lines = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      // a result can never belong to the event taken at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (lines_due.size() == 0) begin
          $error("unexpected result: lines %0d", $signed(m_axis_tdata_i));
          fail_cnt_o++;
        end else begin
          want = lines_due.pop_front();
          if (want !== m_axis_tdata_i) begin
            $error("lines mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(m_axis_tdata_i));
            fail_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        lines_due.push_back(snap_event(s_axis_tuser_i, s_axis_tdata_i[15:0],
                                       s_axis_tdata_i[47:16], s_axis_tdata_i[55:48],
                                       s_axis_tdata_i[71:56]));
      end
      due_cnt_o = lines_due.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/scroll_to_line_snapper_tb.sv
// ----------------------------------------------------------------------------
// scroll_to_line_snapper_tb
// Drives scroll gestures, line scrolls and random events into the line
// snapper under several gain settings, with random stalls on both streams,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module scroll_to_line_snapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 98;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [71:0] s_data;
  logic [2:0]  s_user;
  logic        m_valid;
  logic        m_ready;
  logic [15:0] m_data;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;
  int          fail_cnt;
  int          due_cnt;

  logic        s_fire;
  logic [31:0] now_ms;
  logic [7:0]  row_px;
  bit          quiet;
  bit          sender_idles;
  bit          hold_req;
  int unsigned sent_cnt;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  scroll_to_line_snapper u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  scroll_to_line_snapper_chk u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .fail_cnt_o      (fail_cnt),
    .due_cnt_o       (due_cnt)
  );

  // event transfer seen at the edge, read back at the following falling edge
  always @(posedge clk_i) s_fire <= s_valid & s_ready;

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      2:       return 16'(int'($urandom_range(0, 4000)) - 2000);
      3:       return 16'(int'($urandom_range(0, 6)) - 3);
      default: return 16'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  function automatic logic [7:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'($urandom_range(1, 8));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_view();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
  endfunction

  task automatic send_event(input logic [2:0] fn, input logic [15:0] amt,
                            input logic [31:0] stamp, input logic [7:0] height,
                            input logic [15:0] view);
    int unsigned gap;
    gap = 0;
    if (!quiet && sender_idles && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= fn;
    s_data  <= {view, height, stamp, amt};
    do @(negedge clk_i); while (!s_fire);
    sent_cnt++;
  endtask

  task automatic send_ctrl(input logic [2:0] fn);
    if ($urandom_range(0, 39) == 0) now_ms = $urandom;
    else now_ms = now_ms + $urandom_range(0, 80);
    send_event(fn, pick_amount(), now_ms, pick_height(), pick_view());
  endtask

  task automatic send_scroll(input logic [2:0] fn);
    logic [7:0] height;
    now_ms = now_ms + $urandom_range(0, 20);
    height = ($urandom_range(0, 9) == 0) ? pick_height() : row_px;
    send_event(fn, pick_amount(), now_ms, height, pick_view());
  endtask

  // touch, drag, release, then often a fling that may keep the halt flags
  task automatic run_gesture();
    int unsigned n;
    sender_idles = ($urandom_range(0, 3) != 0);
    row_px = 8'($urandom_range(1, 255));
    send_ctrl(FUNC_MOTION_START);
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0)
        send_ctrl(($urandom_range(0, 1) != 0) ? FUNC_HALT_UP : FUNC_HALT_DOWN);
      send_scroll(FUNC_PIXEL);
    end
    send_ctrl(FUNC_MOTION_STOP);
    if ($urandom_range(0, 3) != 0) begin
      send_ctrl(FUNC_INERTIA_START);
      n = $urandom_range(0, 8);
      repeat (n) send_scroll(FUNC_PIXEL);
      send_ctrl(FUNC_INERTIA_STOP);
    end
  endtask

  task automatic settle(input int unsigned extra);
    s_valid <= 1'b0;
    do @(negedge clk_i); while (due_cnt != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] pix, input logic [23:0] gain,
                              input logic vb, input logic [15:0] floor_lines);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PIXEL_SCALE;
    cfg_wdata <= 24'(pix);
    @(negedge clk_i);
    cfg_addr  <= REG_LINE_SCALE;
    cfg_wdata <= gain;
    @(negedge clk_i);
    cfg_addr  <= REG_VIEW_BASED;
    cfg_wdata <= 24'(vb);
    @(negedge clk_i);
    cfg_addr  <= REG_MIN_LINES;
    cfg_wdata <= 24'(floor_lines);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin : sink
    int unsigned span;
    bit          hold_done;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        // long back-pressure so the block fills up and drops its ready
        hold_done = 1'b1;
        m_ready <= 1'b0;
        span = LONG_HOLD;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        span = $urandom_range(1, 17);
      end else begin
        m_ready <= 1'b1;
        span = $urandom_range(1, 40);
      end
      repeat (span) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("scroll_to_line_snapper regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned target;
    int unsigned pick;
    rst_ni       = 1'b0;
    s_valid      = 1'b0;
    s_data       = '0;
    s_user       = '0;
    m_ready      = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    quiet        = 1'b0;
    sender_idles = 1'b1;
    hold_req     = 1'b0;
    sent_cnt     = 0;
    now_ms       = 32'd1000;
    row_px       = 8'd16;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed events under the reset gains
    send_event(FUNC_PIXEL, 16'd5, 32'd1000, 8'd0, 16'd10);          // zero height
    send_event(FUNC_LINE, 16'd0, 32'd1001, 8'd16, 16'd10);          // zero lines, floor 1
    send_event(FUNC_LINE, 16'h7fff, 32'd1002, 8'd16, 16'hffff);
    send_event(FUNC_LINE, 16'h8000, 32'd1003, 8'd16, 16'hffff);
    send_event(FUNC_PIXEL, 16'h7fff, 32'd1004, 8'd1, 16'd0);
    send_event(FUNC_PIXEL, 16'h8000, 32'd1005, 8'd1, 16'd0);
    send_event(FUNC_MOTION_START, 16'd0, 32'd1010, 8'd64, 16'd0);
    send_event(FUNC_PIXEL, 16'd100, 32'd1011, 8'd64, 16'd0);
    // reversal drops the carried remainder
    send_event(FUNC_PIXEL, -16'sd10, 32'd1012, 8'd64, 16'd0);
    send_event(FUNC_PIXEL, -16'sd60, 32'd1013, 8'd64, 16'd0);
    send_event(FUNC_HALT_UP, 16'd0, 32'd1014, 8'd64, 16'd0);
    send_event(FUNC_PIXEL, -16'sd20, 32'd1015, 8'd64, 16'd0);
    send_event(FUNC_PIXEL, 16'd20, 32'd1016, 8'd64, 16'd0);
    send_event(FUNC_HALT_DOWN, 16'd0, 32'd1017, 8'd64, 16'd0);
    send_event(FUNC_PIXEL, 16'd5, 32'd1018, 8'd64, 16'd0);
    send_event(FUNC_MOTION_STOP, 16'd0, 32'd2000, 8'd64, 16'd0);
    send_event(FUNC_INERTIA_START, 16'd0, 32'd2049, 8'd64, 16'd0);  // halts kept
    send_event(FUNC_PIXEL, -16'sd5, 32'd2050, 8'd64, 16'd0);
    send_event(FUNC_INERTIA_STOP, 16'd0, 32'd3000, 8'd64, 16'd0);
    send_event(FUNC_INERTIA_START, 16'd0, 32'd3050, 8'd64, 16'd0);  // halts cleared
    send_event(FUNC_PIXEL, -16'sd5, 32'd3051, 8'd64, 16'd0);
    send_event(FUNC_HALT_DOWN, 16'd0, 32'd3052, 8'd64, 16'd0);
    // stop time close to the wrap of the millisecond counter
    send_event(FUNC_MOTION_STOP, 16'd0, 32'hffff_fff0, 8'd64, 16'd0);
    send_event(FUNC_INERTIA_START, 16'd0, 32'h0000_0010, 8'd64, 16'd0);
    send_event(FUNC_PIXEL, 16'd3, 32'h0000_0011, 8'd64, 16'd0);
    send_event(FUNC_HALT_UP, 16'hffff, 32'hffff_ffff, 8'hff, 16'hffff);
    send_event(FUNC_INERTIA_STOP, 16'd0, 32'h0000_0020, 8'd64, 16'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      settle(4);
      case (ph)
        0: program_regs(PIXEL_SCALE_RST, LINE_SCALE_RST, 1'b0, MIN_LINES_RST);
        1: program_regs(16'd1, 24'd1, 1'b1, 16'd0);
        2: program_regs(16'hffff, 24'hff_ffff, 1'b1, 16'hffff);
        3: program_regs(16'd128, 24'd32768, 1'b0, 16'd0);                // half gains
        default: program_regs(($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 65535))
                                                          : 16'($urandom_range(64, 768)),
                              ($urandom_range(0, 1) != 0) ? 24'($urandom_range(1, 24'hff_ffff))
                                                          : 24'($urandom_range(8192, 262144)),
                              1'($urandom),
                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3)));
      endcase
      if (ph == 1) hold_req = 1'b1;
      if (ph == PHASES - 1) quiet = 1'b1;
      target = sent_cnt + PHASE_ITEMS;
      while (sent_cnt < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          run_gesture();
        end else if (pick < 17) begin
          sender_idles = ($urandom_range(0, 3) != 0);
          repeat (3) send_scroll(FUNC_LINE);
        end else begin
          send_event(3'($urandom), 16'($urandom), 32'($urandom), 8'($urandom), 16'($urandom));
        end
      end
    end

    settle(TAIL_CYCLES);
    if (fail_cnt == 0) begin
      $display("scroll_to_line_snapper regression: pass");
    end else begin
      $display("scroll_to_line_snapper regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
